FILE: hdl/ldq_pkg.sv
// Shared operation and status codes for the linked deque.
`timescale 1ns / 1ps
package ldq_pkg;
   localparam logic [2:0] OP_PUSH_HEAD = 3'd0;
   localparam logic [2:0] OP_PUSH_TAIL = 3'd1;
   localparam logic [2:0] OP_POP_HEAD  = 3'd2;
   localparam logic [2:0] OP_POP_TAIL  = 3'd3;
   localparam logic [2:0] OP_REMOVE    = 3'd4;
   localparam logic [2:0] OP_ITER_START = 3'd5;
   localparam logic [2:0] OP_ITER_NEXT = 3'd6;
   localparam logic [2:0] OP_ITER_END  = 3'd7;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;
endpackage

FILE: hdl/ldq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ldq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hdl/linked_deque_with_remove.sv
// Linked deque top level: node store in one RAM, sequencer for all operations.
// Remove walks back from the tail over at most CAPACITY entries, each read through
// the single node RAM read port.
// One request at a time; busy drops again in the result cycle. Reset: synchronous,
// clears list pointers, count and cursor, not the RAM; the receiver cannot stall.
`timescale 1ns / 1ps
module linked_deque_with_remove
   import ldq_pkg::*;
#(
   parameter int CAPACITY    = 256,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_kind,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_data_out,
   output logic [31:0]            rsp_head_value,
   output logic [31:0]            rsp_tail_value,
   output logic [8:0]             rsp_item_count
);
   localparam int AW = $clog2(CAPACITY);
   localparam int IW = AW + 1;               // index incl. none marker
   localparam int NW = VALUE_WIDTH + 2 * IW; // value, next, prev
   localparam logic [IW-1:0] NONE = IW'(CAPACITY);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;  // target node read resolves
   localparam logic [3:0] S_HINT  = 4'd2;  // cursor node read
   localparam logic [3:0] S_HINTP = 4'd3;  // predecessor of cursor read
   localparam logic [3:0] S_WALK  = 4'd4;  // walk node read
   localparam logic [3:0] S_UN0   = 4'd5;  // unlink: free node, read prev neighbour
   localparam logic [3:0] S_UN1   = 4'd6;  // unlink: patch prev, read next neighbour
   localparam logic [3:0] S_UN2   = 4'd7;  // unlink: patch next neighbour
   localparam logic [3:0] S_NB    = 4'd8;  // push: write new node, read old end node
   localparam logic [3:0] S_NB2   = 4'd9;  // push: patch old end node
   localparam logic [3:0] S_ENDS  = 4'd10; // read head node value
   localparam logic [3:0] S_ENDS2 = 4'd11; // read tail node value
   localparam logic [3:0] S_DONE  = 4'd12;
   localparam logic [3:0] S_FREE  = 4'd13; // push: read free pool node
   localparam logic [3:0] S_WAIT  = 4'd14; // generic read wait

   logic [3:0] state_ff, state_in, ret_ff, ret_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   logic [IW-1:0] fresh_ff, fresh_in, cur_ff, cur_in;
   logic [IW-1:0] count_ff, count_in;
   logic [2:0] kind_ff, kind_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [IW-1:0] n_ff, n_in, nx_ff, nx_in, pv_ff, pv_in;
   logic [IW-1:0] steps_ff, steps_in;
   logic [1:0] status_ff, status_in;
   logic [VALUE_WIDTH-1:0] data_ff, data_in, hv_ff, hv_in;
   logic valid_ff, valid_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr, rd_addr_ff;
   logic [NW-1:0] wr_data, rd_data;
   logic [VALUE_WIDTH-1:0] rd_val;
   logic [IW-1:0] rd_nx, rd_pv;

   ldq_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_nodes (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_val = rd_data[NW-1 -: VALUE_WIDTH];
   assign rd_nx  = rd_data[2*IW-1 -: IW];
   assign rd_pv  = rd_data[IW-1:0];

   function automatic logic ok_idx(input logic [IW-1:0] i);
      return i < IW'(CAPACITY);
   endfunction

   function automatic logic [NW-1:0] node(input logic [VALUE_WIDTH-1:0] v,
                                          input logic [IW-1:0] nx,
                                          input logic [IW-1:0] pv);
      return {v, nx, pv};
   endfunction

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      head_in = head_ff; tail_in = tail_ff; free_in = free_ff;
      fresh_in = fresh_ff; cur_in = cur_ff; count_in = count_ff;
      kind_in = kind_ff; val_in = val_ff;
      n_in = n_ff; nx_in = nx_ff; pv_in = pv_ff; steps_in = steps_ff;
      status_in = status_ff; data_in = data_ff; hv_in = hv_ff;
      valid_in = 1'b0;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      rd_addr = rd_addr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind; val_in = req_value;
               status_in = ST_OK; data_in = '0;
               state_in = S_ENDS;
               unique case (req_kind)
                  OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                     if (count_ff >= IW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (ok_idx(free_ff)) begin
                        n_in = free_ff; rd_addr = free_ff[AW-1:0];
                        state_in = S_FREE;
                     end else if (!ok_idx(fresh_ff)) begin
                        status_in = ST_FULL;
                     end else begin
                        n_in = fresh_ff; fresh_in = fresh_ff + 1'b1;
                        state_in = S_NB;
                     end
                  end
                  OP_POP_HEAD, OP_POP_TAIL: begin
                     n_in = (req_kind == OP_POP_HEAD) ? head_ff : tail_ff;
                     if (!ok_idx(n_in)) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_addr = n_in[AW-1:0];
                        state_in = S_WAIT; ret_in = S_RD;
                     end
                  end
                  OP_REMOVE: begin
                     status_in = ST_NOT_FOUND;
                     if (ok_idx(head_ff)) begin
                        steps_in = '0;
                        if (ok_idx(cur_ff)) begin
                           n_in = cur_ff; rd_addr = cur_ff[AW-1:0];
                           state_in = S_WAIT; ret_in = S_HINT;
                        end else begin
                           n_in = tail_ff; rd_addr = tail_ff[AW-1:0];
                           state_in = S_WAIT; ret_in = S_WALK;
                        end
                     end
                  end
                  OP_ITER_START: cur_in = head_ff;
                  OP_ITER_NEXT: begin
                     if (!ok_idx(cur_ff)) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_addr = cur_ff[AW-1:0];
                        state_in = S_WAIT; ret_in = S_RD;
                     end
                  end
                  default: cur_in = NONE;
               endcase
            end
         end
         S_WAIT: state_in = ret_ff;
         S_RD: begin
            // node read for pop or iteration next
            data_in = rd_val;
            if (kind_ff == OP_ITER_NEXT) begin
               cur_in = rd_nx; state_in = S_ENDS;
            end else begin
               nx_in = rd_nx; pv_in = rd_pv; state_in = S_UN0;
            end
         end
         S_HINT: begin
            if (rd_val == val_ff) begin
               nx_in = rd_nx; pv_in = rd_pv; state_in = S_UN0;
               status_in = ST_OK;
            end else if (ok_idx(rd_pv)) begin
               n_in = rd_pv; rd_addr = rd_pv[AW-1:0];
               state_in = S_WAIT; ret_in = S_HINTP;
            end else begin
               n_in = tail_ff; rd_addr = tail_ff[AW-1:0];
               state_in = S_WAIT; ret_in = S_WALK;
            end
         end
         S_HINTP: begin
            if (rd_val == val_ff) begin
               nx_in = rd_nx; pv_in = rd_pv; state_in = S_UN0;
               status_in = ST_OK;
            end else begin
               n_in = tail_ff; rd_addr = tail_ff[AW-1:0];
               state_in = S_WAIT; ret_in = S_WALK;
            end
         end
         S_WALK: begin
            if (rd_val == val_ff) begin
               nx_in = rd_nx; pv_in = rd_pv; state_in = S_UN0;
               status_in = ST_OK;
            end else if (ok_idx(rd_pv) && (steps_ff < IW'(CAPACITY - 1))) begin
               steps_in = steps_ff + 1'b1;
               n_in = rd_pv; rd_addr = rd_pv[AW-1:0];
               state_in = S_WAIT; ret_in = S_WALK;
            end else begin
               state_in = S_ENDS;
            end
         end
         S_UN0: begin
            // free the node, fix list ends and cursor; read prev neighbour
            wr_en = 1'b1; wr_addr = n_ff[AW-1:0];
            wr_data = node('0, free_ff, NONE);
            free_in = n_ff;
            if (cur_ff == n_ff) cur_in = nx_ff;
            if (head_ff == n_ff) head_in = nx_ff;
            if (tail_ff == n_ff) tail_in = pv_ff;
            if (count_ff != '0) count_in = count_ff - 1'b1;
            if (ok_idx(pv_ff)) begin
               rd_addr = pv_ff[AW-1:0];
               state_in = S_WAIT; ret_in = S_UN1;
            end else begin
               state_in = S_UN1;
            end
         end
         S_UN1: begin
            if (ok_idx(pv_ff)) begin
               wr_en = 1'b1; wr_addr = pv_ff[AW-1:0];
               wr_data = node(rd_val, nx_ff, rd_pv);
            end
            if (ok_idx(nx_ff)) begin
               rd_addr = nx_ff[AW-1:0];
               state_in = S_WAIT; ret_in = S_UN2;
            end else begin
               state_in = S_ENDS;
            end
         end
         S_UN2: begin
            wr_en = 1'b1; wr_addr = nx_ff[AW-1:0];
            wr_data = node(rd_val, rd_nx, pv_ff);
            state_in = S_ENDS;
         end
         S_FREE: begin
            // pool node read resolves: next free entry is its forward link
            free_in = rd_nx; state_in = S_NB;
         end
         S_NB: begin
            // write new node, read old end neighbour for patching
            wr_en = 1'b1; wr_addr = n_ff[AW-1:0];
            count_in = count_ff + 1'b1;
            if (kind_ff == OP_PUSH_HEAD) begin
               wr_data = node(val_ff, head_ff, NONE);
               nx_in = head_ff;
               head_in = n_ff;
               if (!ok_idx(tail_ff)) tail_in = n_ff;
            end else begin
               wr_data = node(val_ff, NONE, tail_ff);
               nx_in = tail_ff;
               tail_in = n_ff;
               if (!ok_idx(head_ff)) head_in = n_ff;
            end
            if (ok_idx(nx_in)) begin
               rd_addr = nx_in[AW-1:0];
               state_in = S_WAIT; ret_in = S_NB2;
            end else begin
               state_in = S_ENDS;
            end
         end
         S_NB2: begin
            wr_en = 1'b1; wr_addr = nx_ff[AW-1:0];
            if (kind_ff == OP_PUSH_HEAD) wr_data = node(rd_val, rd_nx, n_ff);
            else                         wr_data = node(rd_val, n_ff, rd_pv);
            state_in = S_ENDS;
         end
         S_ENDS: begin
            rd_addr = head_ff[AW-1:0];
            state_in = S_WAIT; ret_in = S_ENDS2;
         end
         S_ENDS2: begin
            hv_in = ok_idx(head_ff) ? rd_val : '0;
            rd_addr = tail_ff[AW-1:0];
            state_in = S_WAIT; ret_in = S_DONE;
         end
         S_DONE: begin
            valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ret_ff <= S_IDLE;
         head_ff <= NONE; tail_ff <= NONE; free_ff <= NONE; cur_ff <= NONE;
         fresh_ff <= '0; count_ff <= '0; valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in;
         head_ff <= head_in; tail_ff <= tail_in; free_ff <= free_in;
         cur_ff <= cur_in; fresh_ff <= fresh_in; count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      kind_ff <= kind_in; val_ff <= val_in; n_ff <= n_in;
      nx_ff <= nx_in; pv_ff <= pv_in; steps_ff <= steps_in;
      status_ff <= status_in; data_ff <= data_in; hv_ff <= hv_in;
      rd_addr_ff <= rd_addr;
   end

   // hold the result for its one-cycle beat
   logic [VALUE_WIDTH-1:0] tv_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE) tv_ff <= ok_idx(tail_ff) ? rd_val : '0;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_data_out   = 32'(data_ff);
   assign rsp_head_value = 32'(hv_ff);
   assign rsp_tail_value = 32'(tv_ff);
   assign rsp_item_count = 9'(count_ff);
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the linked deque: directed table, fill and drain, then random beats.
`timescale 1ns / 1ps
module testbench
   import ldq_pkg::*;
();

   localparam int CAP = 256;
   localparam logic [8:0] NIL = 9'd256;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_kind = OP_ITER_END;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_data_out, rsp_head_value, rsp_tail_value;
   logic [8:0]  rsp_item_count;

   linked_deque_with_remove dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_data_out(rsp_data_out),
      .rsp_head_value(rsp_head_value), .rsp_tail_value(rsp_tail_value),
      .rsp_item_count(rsp_item_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data;
      logic [31:0] head;
      logic [31:0] tail;
      logic [8:0]  count;
   } deque_reply_type;

   // Mirror of the node store held by the deque.
   logic [31:0] node_val [CAP];
   logic [8:0]  node_nxt [CAP];
   logic [8:0]  node_prv [CAP];
   logic [8:0]  hd, tl, pool, fresh, cnt, cur;

   deque_reply_type replies_due[$];
   int errors = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic logic [8:0] grab_node();
      logic [8:0] n;
      if (pool != NIL) begin
         n = pool;
         pool = node_nxt[n];
      end else begin
         n = fresh;
         fresh++;
      end
      return n;
   endfunction

   function automatic void unlink_node(input logic [8:0] n);
      logic [8:0] nx, pv;
      nx = node_nxt[n];
      pv = node_prv[n];
      if (cur == n) cur = nx;
      if (pv != NIL) node_nxt[pv] = nx;
      if (nx != NIL) node_prv[nx] = pv;
      if (hd == n) hd = nx;
      if (tl == n) tl = pv;
      node_val[n] = '0;
      node_prv[n] = NIL;
      node_nxt[n] = pool;
      pool = n;
      if (cnt > 0) cnt--;
   endfunction

   // Apply one operation to the mirror and return the reply it should give.
   function automatic deque_reply_type deque_apply(input logic [2:0] kind, input logic [31:0] v);
      deque_reply_type r;
      logic [8:0] n, c;
      bit done;
      r = '0;
      case (kind)
         OP_PUSH_HEAD, OP_PUSH_TAIL: begin
            if (cnt >= CAP) begin
               r.status = ST_FULL;
            end else begin
               n = grab_node();
               node_val[n] = v;
               if (kind == OP_PUSH_HEAD) begin
                  node_prv[n] = NIL;
                  node_nxt[n] = hd;
                  if (hd != NIL) node_prv[hd] = n;
                  hd = n;
                  if (tl == NIL) tl = n;
               end else begin
                  node_nxt[n] = NIL;
                  node_prv[n] = tl;
                  if (tl != NIL) node_nxt[tl] = n;
                  tl = n;
                  if (hd == NIL) hd = n;
               end
               cnt++;
            end
         end
         OP_POP_HEAD, OP_POP_TAIL: begin
            n = (kind == OP_POP_HEAD) ? hd : tl;
            if (n == NIL) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = node_val[n];
               unlink_node(n);
            end
         end
         OP_REMOVE: begin
            r.status = ST_NOT_FOUND;
            done = 0;
            if (hd != NIL) begin
               if (cur != NIL) begin
                  c = cur;
                  if (node_val[c] == v) begin
                     unlink_node(c);
                     done = 1;
                  end else if (node_prv[c] != NIL && node_val[node_prv[c]] == v) begin
                     unlink_node(node_prv[c]);
                     done = 1;
                  end
               end
               n = tl;
               for (int s = 0; !done && n != NIL && s < CAP; s++) begin
                  if (node_val[n] == v) begin
                     unlink_node(n);
                     done = 1;
                  end else begin
                     n = node_prv[n];
                  end
               end
               if (done) r.status = ST_OK;
            end
         end
         OP_ITER_START: cur = hd;
         OP_ITER_NEXT: begin
            if (cur == NIL) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = node_val[cur];
               cur = node_nxt[cur];
            end
         end
         default: cur = NIL;
      endcase
      r.head = (hd != NIL) ? node_val[hd] : '0;
      r.tail = (tl != NIL) ? node_val[tl] : '0;
      r.count = cnt;
      return r;
   endfunction

   // Check every reply beat against the oldest expectation.
   always @(posedge clock) begin
      deque_reply_type w;
      if (!reset && rsp_valid) begin
         if (replies_due.size() == 0) begin
            report("unexpected beat", 32'(rsp_status), 0);
         end else begin
            w = replies_due.pop_front();
            if (rsp_status !== w.status) report("status", 32'(rsp_status), 32'(w.status));
            if (rsp_data_out !== w.data) report("data_out", rsp_data_out, w.data);
            if (rsp_head_value !== w.head) report("head_value", rsp_head_value, w.head);
            if (rsp_tail_value !== w.tail) report("tail_value", rsp_tail_value, w.tail);
            if (rsp_item_count !== w.count)
               report("item_count", 32'(rsp_item_count), 32'(w.count));
         end
      end
   end

   int sender_gap_pct = 30;

   // Issue one request beat; hold start until it is taken, then queue the reply.
   // Start stays high after the accepting edge; the next beat or the caller drops it.
   task automatic send_beat(input logic [2:0] kind, input logic [31:0] v,
                            input bit typed, input deque_reply_type typed_reply);
      deque_reply_type p;
      while ($urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_value <= v;
      do @(posedge clock); while (busy);
      p = deque_apply(kind, v);
      replies_due.push_back(typed ? typed_reply : p);
   endtask

   typedef struct {
      logic [2:0] kind;
      logic [31:0] v;
      bit typed;
      deque_reply_type reply;
   } stim_row_type;

   // Random value drawn mostly from a small pool so removes find matches.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2, 3: return $urandom;
         default: return $urandom_range(12);
      endcase
   endfunction

   initial begin
      stim_row_type rows[$];
      int pct;
      logic [2:0] k;
      rows = '{
         '{OP_POP_HEAD,  32'h0,         1, '{ST_EMPTY, 0, 0, 0, 0}},
         '{OP_POP_TAIL,  32'h0,         1, '{ST_EMPTY, 0, 0, 0, 0}},
         '{OP_REMOVE,    32'h5,         1, '{ST_NOT_FOUND, 0, 0, 0, 0}},
         '{OP_ITER_NEXT, 32'h0,         1, '{ST_EMPTY, 0, 0, 0, 0}},
         '{OP_ITER_START,32'h0,         1, '{ST_OK, 0, 0, 0, 0}},
         '{OP_PUSH_HEAD, 32'hFFFF_FFFF, 1, '{ST_OK, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1}},
         '{OP_PUSH_TAIL, 32'h0,         1, '{ST_OK, 0, 32'hFFFF_FFFF, 0, 2}},
         '{OP_PUSH_TAIL, 32'h7,         0, '0},
         '{OP_PUSH_HEAD, 32'h7,         0, '0},
         '{OP_PUSH_TAIL, 32'hA5A5_5A5A, 0, '0},
         '{OP_ITER_START,32'h0,         0, '0},
         '{OP_ITER_NEXT, 32'h0,         0, '0},
         '{OP_ITER_NEXT, 32'h0,         0, '0},
         '{OP_REMOVE,    32'hFFFF_FFFF, 0, '0},   // the entry before the cursor
         '{OP_REMOVE,    32'h0,         0, '0},   // the cursor entry itself
         '{OP_REMOVE,    32'h7,         0, '0},   // duplicate, nearest the tail
         '{OP_REMOVE,    32'h1234,      0, '0},   // absent value
         '{OP_ITER_NEXT, 32'h0,         0, '0},
         '{OP_ITER_NEXT, 32'h0,         0, '0},
         '{OP_ITER_END,  32'h0,         0, '0},
         '{OP_POP_TAIL,  32'h0,         0, '0},
         '{OP_POP_HEAD,  32'h0,         0, '0}
      };
      hd = NIL; tl = NIL; pool = NIL; cur = NIL; fresh = 0; cnt = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_beat(rows[i].kind, rows[i].v, rows[i].typed, rows[i].reply);

      // Fill past capacity, drain, then pause for the queue to empty.
      for (int i = 0; i < CAP + 2; i++) send_beat(OP_PUSH_TAIL, $urandom, 0, '0);
      send_beat(OP_PUSH_HEAD, 32'h1, 0, '0);
      for (int i = 0; i < CAP + 1; i++) send_beat($urandom_range(1) ? OP_POP_HEAD : OP_POP_TAIL,
                                                 0, 0, '0);
      start <= 1'b0;
      wait (replies_due.size() == 0);

      // Random phases: sender idle chance 30 percent, then 53 percent, then never.
      for (int ph = 0; ph < 3; ph++) begin
         sender_gap_pct = (ph == 0) ? 30 : (ph == 1) ? 53 : 0;
         for (int i = 0; i < 100; i++) begin
            pct = $urandom_range(99);
            // Bias towards pushes while short so removes and walks have depth.
            if (pct < ((cnt < 20) ? 45 : 25)) k = $urandom_range(1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
            else if (pct < 60) k = OP_REMOVE;
            else k = 3'($urandom_range(7));
            send_beat(k, pick_value(), 0, '0);
         end
      end

      start <= 1'b0;
      wait (replies_due.size() == 0);
      repeat (2 * CAP + 20) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: generous bound on the slowest correct run.
   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
